@@ rtl/adam_pkg.sv @@
// adam_pkg: shared types, widths, register codes and fixed-point helpers
// for the adam / sgd parameter update core; no dependencies
package adam_pkg;

  localparam int DATA_W     = 32;
  localparam int UDATA_W    = 31;
  localparam int FRAC_W     = 24;
  localparam int COEF_W     = 25;
  localparam int CNT_W      = 16;
  localparam int PROD_W     = 58;
  localparam int SQ_W       = 63;
  localparam int ROOT_W     = 28;
  localparam int DEN_W      = 29;
  localparam int GNUM_W     = 32;
  localparam int VNUM_W     = 55;
  localparam int QNUM_W     = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CNT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BC1  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BC2  = 3'd7;

  localparam logic MODE_ADAM = 1'b0;
  localparam logic MODE_SGD  = 1'b1;

  localparam logic signed [63:0] SMAX       = 64'sd2147483647;
  localparam logic signed [63:0] SMIN       = -64'sd2147483648;
  localparam logic signed [63:0] TRUNC_BIAS = (64'sd1 <<< FRAC_W) - 64'sd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] weight_in;
    logic signed [DATA_W-1:0] grad_sum;
    logic signed [DATA_W-1:0] moment_one_in;
    logic [UDATA_W-1:0]       moment_two_in;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] weight_out;
    logic signed [DATA_W-1:0] moment_one_out;
    logic [UDATA_W-1:0]       moment_two_out;
  } out_t;

  typedef struct packed {
    logic              mode;
    logic [COEF_W-1:0] lr;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] omb1;
    logic [COEF_W-1:0] b2;
    logic [COEF_W-1:0] omb2;
    logic [COEF_W-1:0] eps;
    logic [CNT_W-1:0]  n;
    logic [COEF_W-1:0] bc1;
    logic [COEF_W-1:0] bc2;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] w;
    logic signed [DATA_W-1:0] m_in;
    logic [UDATA_W-1:0]       v_in;
    logic signed [DATA_W-1:0] sgd_step;
    logic signed [DATA_W-1:0] m1;
    logic [UDATA_W-1:0]       v1;
    logic [DEN_W-1:0]         den;
    logic                     neg;
  } carry_t;

  function automatic logic signed [63:0] sx32(input logic signed [DATA_W-1:0] x);
    return {{(64-DATA_W){x[DATA_W-1]}}, x};
  endfunction

  function automatic logic signed [63:0] sxp(input logic signed [PROD_W-1:0] x);
    return {{(64-PROD_W){x[PROD_W-1]}}, x};
  endfunction

  // product scaled back by 2^frac, rounded toward zero
  function automatic logic signed [63:0] trunc_q(input logic signed [63:0] p);
    logic signed [63:0] bias;
    bias = p[63] ? TRUNC_BIAS : 64'sd0;
    return (p + bias) >>> FRAC_W;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_s(input logic signed [63:0] x);
    logic signed [63:0] c;
    if (x > SMAX) begin
      c = SMAX;
    end else if (x < SMIN) begin
      c = SMIN;
    end else begin
      c = x;
    end
    return c[DATA_W-1:0];
  endfunction

  function automatic logic [UDATA_W-1:0] sat_u(input logic signed [63:0] x);
    logic signed [63:0] c;
    if (x > SMAX) begin
      c = SMAX;
    end else if (x < 64'sd0) begin
      c = 64'sd0;
    end else begin
      c = x;
    end
    return c[UDATA_W-1:0];
  endfunction

endpackage

@@ rtl/adam_cfg_regs.sv @@
// adam_cfg_regs: configuration register file with range clamping on write
// depends on adam_pkg
module adam_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [adam_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [adam_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output adam_pkg::cfg_t                   cfg_o
);
  import adam_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic [COEF_W-1:0] raw;

  function automatic logic [COEF_W-1:0] clamp_coef(input logic [COEF_W-1:0] v,
                                                   input logic zero_is_one);
    if (v > COEF_ONE) begin
      return COEF_ONE;
    end
    if (zero_is_one && v == '0) begin
      return COEF_W'(1);
    end
    return v;
  endfunction

  assign raw = cfg_data_i[COEF_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE: cfg_d.mode = cfg_data_i[0];
        REG_LR:   cfg_d.lr = raw;
        REG_B1: begin
          cfg_d.b1   = clamp_coef(raw, 1'b0);
          cfg_d.omb1 = COEF_ONE - clamp_coef(raw, 1'b0);
        end
        REG_B2: begin
          cfg_d.b2   = clamp_coef(raw, 1'b0);
          cfg_d.omb2 = COEF_ONE - clamp_coef(raw, 1'b0);
        end
        REG_EPS:  cfg_d.eps = clamp_coef(raw, 1'b1);
        REG_CNT:  cfg_d.n = (cfg_data_i[CNT_W-1:0] == '0) ? CNT_W'(1) : cfg_data_i[CNT_W-1:0];
        REG_BC1:  cfg_d.bc1 = clamp_coef(raw, 1'b1);
        REG_BC2:  cfg_d.bc2 = clamp_coef(raw, 1'b1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= MODE_ADAM;
      cfg_q.lr   <= 25'd16777;
      cfg_q.b1   <= 25'd15099494;
      cfg_q.omb1 <= 25'd1677722;
      cfg_q.b2   <= 25'd16760439;
      cfg_q.omb2 <= 25'd16777;
      cfg_q.eps  <= 25'd1;
      cfg_q.n    <= 16'd1;
      cfg_q.bc1  <= COEF_ONE;
      cfg_q.bc2  <= COEF_ONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  a_b1_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.b1 + cfg_q.omb1 == COEF_ONE) else $error("beta one pair inconsistent");
  a_b2_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.b2 + cfg_q.omb2 == COEF_ONE) else $error("beta two pair inconsistent");
  a_bc_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.bc1 != '0 && cfg_q.bc1 <= COEF_ONE && cfg_q.bc2 != '0 && cfg_q.bc2 <= COEF_ONE)
    else $error("bias correction out of range");
  a_div_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.n != '0 && cfg_q.eps != '0) else $error("zero divisor term");

endmodule

@@ rtl/adam_div_pipe.sv @@
// adam_div_pipe: pipelined restoring unsigned divider, one quotient bit
// per stage, with a tag riding alongside; no package dependency
module adam_div_pipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [NUM_W-1:0] vld_q;
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] rem_d [NUM_W];
  logic [NUM_W-1:0] sh_q  [NUM_W];
  logic [NUM_W-1:0] sh_d  [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [DEN_W-1:0] den_d [NUM_W];
  logic [TAG_W-1:0] tag_q [NUM_W];
  logic [TAG_W-1:0] tag_d [NUM_W];

  always_comb begin
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] sh_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    for (int i = 0; i < NUM_W; i++) begin
      if (i == 0) begin
        rem_in = '0;
        sh_in  = num_i;
        den_in = den_i;
        tag_in = tag_i;
      end else begin
        rem_in = rem_q[i-1];
        sh_in  = sh_q[i-1];
        den_in = den_q[i-1];
        tag_in = tag_q[i-1];
      end
      trial    = {rem_in, sh_in[NUM_W-1]};
      diff     = trial - {1'b0, den_in};
      ge       = trial >= {1'b0, den_in};
      rem_d[i] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh_d[i]  = {sh_in[NUM_W-2:0], ge};
      den_d[i] = den_in;
      tag_d[i] = tag_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NUM_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_W; i++) begin
        rem_q[i] <= rem_d[i];
        sh_q[i]  <= sh_d[i];
        den_q[i] <= den_d[i];
        tag_q[i] <= tag_d[i];
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quot_o  = sh_q[NUM_W-1];
  assign tag_o   = tag_q[NUM_W-1];

  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> den_i != '0) else $error("divide by zero");
  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NUM_W-1] |-> rem_q[NUM_W-1] < den_q[NUM_W-1]) else $error("remainder not reduced");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_o)) else $error("divider moved while held");

endmodule

@@ rtl/adam_sqrt_pipe.sv @@
// adam_sqrt_pipe: pipelined digit-by-digit integer square root, one root
// bit per stage, with a tag riding alongside; no package dependency
module adam_sqrt_pipe #(
  parameter int ROOT_W = 28,
  parameter int TAG_W  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*ROOT_W-1:0] x_i,
  input  logic [TAG_W-1:0]    tag_i,
  output logic                valid_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [TAG_W-1:0]    tag_o
);

  logic [ROOT_W-1:0]   vld_q;
  logic [ROOT_W:0]     rem_q  [ROOT_W];
  logic [ROOT_W:0]     rem_d  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [ROOT_W-1:0]   root_d [ROOT_W];
  logic [2*ROOT_W-1:0] x_q    [ROOT_W];
  logic [2*ROOT_W-1:0] x_d    [ROOT_W];
  logic [TAG_W-1:0]    tag_q  [ROOT_W];
  logic [TAG_W-1:0]    tag_d  [ROOT_W];

  always_comb begin
    logic [ROOT_W:0]     rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] x_in;
    logic [TAG_W-1:0]    tag_in;
    logic [ROOT_W+2:0]   trial_rem;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   diff;
    logic                ge;
    for (int i = 0; i < ROOT_W; i++) begin
      if (i == 0) begin
        rem_in  = '0;
        root_in = '0;
        x_in    = x_i;
        tag_in  = tag_i;
      end else begin
        rem_in  = rem_q[i-1];
        root_in = root_q[i-1];
        x_in    = x_q[i-1];
        tag_in  = tag_q[i-1];
      end
      trial_rem = {rem_in, x_in[2*ROOT_W-1 -: 2]};
      trial     = {1'b0, root_in, 2'b01};
      diff      = trial_rem - trial;
      ge        = trial_rem >= trial;
      rem_d[i]  = ge ? diff[ROOT_W:0] : trial_rem[ROOT_W:0];
      root_d[i] = {root_in[ROOT_W-2:0], ge};
      x_d[i]    = {x_in[2*ROOT_W-3:0], 2'b00};
      tag_d[i]  = tag_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ROOT_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < ROOT_W; i++) begin
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
        x_q[i]    <= x_d[i];
        tag_q[i]  <= tag_d[i];
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign tag_o   = tag_q[ROOT_W-1];

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ROOT_W-1] |-> rem_q[ROOT_W-1] <= {root_q[ROOT_W-1], 1'b0})
    else $error("root not floor");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_o)) else $error("root pipe moved while held");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i |=> vld_q[0]) else $error("item lost at root entry");

endmodule

@@ rtl/adam_sgd_param_update_core.sv @@
// adam_sgd_param_update_core: streaming adam / sgd update of one element per item
// depends on adam_pkg, adam_cfg_regs, adam_div_pipe, adam_sqrt_pipe
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------
//   in      | in_valid_i/in_stall_o   | in_item_i (in_t)
//   out     | out_valid_o/out_stall_i | out_item_o (out_t)
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the output is not stalled
// most of the pipeline depth is in the bit-per-stage dividers (32 + 55 + 56 + 56) and root (28)
// a stalled output freezes the whole pipeline; nothing is dropped
// reset clears valid bits and loads register defaults
module adam_sgd_param_update_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  adam_pkg::in_t                    in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output adam_pkg::out_t                   out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [adam_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [adam_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import adam_pkg::*;

  localparam int TAG_W = $bits(carry_t);

  cfg_t cfg;
  logic adv;

  carry_t in_c, gq_c, vq_c, sq_c, mq_c, fq_c;
  logic [TAG_W-1:0] gq_t, vq_t, sq_t, mq_t, fq_t;
  logic gq_vld, vq_vld, sq_vld, mq_vld, fq_vld;
  logic [GNUM_W-1:0] in_gabs, gq_quot;
  logic [VNUM_W-1:0] vq_quot;
  logic [ROOT_W-1:0] sq_root;
  logic [QNUM_W-1:0] mq_quot, fq_quot;

  logic b_vld_q, c_vld_q, d_vld_q, e_vld_q, f_vld_q, g_vld_q, h_vld_q;
  logic i_vld_q, j_vld_q, k_vld_q, l_vld_q, out_vld_q;
  carry_t b_c_q, c_c_q, d_c_q, e_c_q, f_c_q, g_c_q, h_c_q, i_c_q, j_c_q, k_c_q, l_c_q;
  carry_t d_c_d, f_c_d, h_c_d, k_c_d;
  logic signed [DATA_W-1:0] b_g_q, b_g_d, i_mhat_q, i_mhat_d, l_step_q, l_step_d;
  logic signed [PROD_W-1:0] c_pm_q, c_pm_d, c_pg_q, c_pg_d, c_plr_q, c_plr_d;
  logic [SQ_W-1:0]          c_pgg_q, c_pgg_d;
  logic [UDATA_W-1:0]       d_gg_q, d_gg_d, g_vhat_q, g_vhat_d;
  logic signed [PROD_W-1:0] e_pv_q, e_pv_d, e_pg_q, e_pg_d, j_p_q, j_p_d;
  logic [DATA_W-1:0]        h_mabs_q, h_mabs_d;
  logic [QNUM_W-1:0]        k_pabs_q, k_pabs_d;
  out_t out_q, out_d;

  adam_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;
  assign adv         = !(out_vld_q && out_stall_i);
  assign in_stall_o  = !adv;

  // mean gradient
  always_comb begin
    in_gabs      = in_item_i.grad_sum[DATA_W-1] ? (~in_item_i.grad_sum + GNUM_W'(1))
                                                : in_item_i.grad_sum;
    in_c          = '0;
    in_c.w        = in_item_i.weight_in;
    in_c.m_in     = in_item_i.moment_one_in;
    in_c.v_in     = in_item_i.moment_two_in;
    in_c.neg      = in_item_i.grad_sum[DATA_W-1];
  end

  adam_div_pipe #(.NUM_W(GNUM_W), .DEN_W(CNT_W), .TAG_W(TAG_W)) u_div_g (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(in_valid_i),
    .num_i(in_gabs), .den_i(cfg.n), .tag_i(in_c),
    .valid_o(gq_vld), .quot_o(gq_quot), .tag_o(gq_t)
  );
  assign gq_c = gq_t;

  always_comb begin
    logic signed [PROD_W-1:0] gx, mx, vx, ggx, hx;
    logic signed [63:0] g64, sq, qx, px;
    // stage b
    b_g_d = gq_c.neg ? $signed(~gq_quot + GNUM_W'(1)) : $signed(gq_quot);
    // stage c
    gx      = {{(PROD_W-DATA_W){b_g_q[DATA_W-1]}}, b_g_q};
    mx      = {{(PROD_W-DATA_W){b_c_q.m_in[DATA_W-1]}}, b_c_q.m_in};
    c_pm_d  = $signed({{(PROD_W-COEF_W){1'b0}}, cfg.b1}) * mx;
    c_pg_d  = $signed({{(PROD_W-COEF_W){1'b0}}, cfg.omb1}) * gx;
    c_plr_d = $signed({{(PROD_W-COEF_W){1'b0}}, cfg.lr}) * gx;
    g64     = sx32(b_g_q);
    sq      = g64 * g64;
    c_pgg_d = sq[SQ_W-1:0];
    // stage d
    d_c_d          = c_c_q;
    d_c_d.m1       = sat_s(trunc_q(sxp(c_pm_q)) + trunc_q(sxp(c_pg_q)));
    d_c_d.sgd_step = sat_s(trunc_q(sxp(c_plr_q)));
    d_gg_d         = sat_u(trunc_q($signed({1'b0, c_pgg_q})));
    // stage e
    vx     = {{(PROD_W-UDATA_W){1'b0}}, d_c_q.v_in};
    ggx    = {{(PROD_W-UDATA_W){1'b0}}, d_gg_q};
    e_pv_d = $signed({{(PROD_W-COEF_W){1'b0}}, cfg.b2}) * vx;
    e_pg_d = $signed({{(PROD_W-COEF_W){1'b0}}, cfg.omb2}) * ggx;
    // stage f
    f_c_d    = e_c_q;
    f_c_d.v1 = sat_u(trunc_q(sxp(e_pv_q)) + trunc_q(sxp(e_pg_q)));
    // stage g
    g_vhat_d = (|vq_quot[VNUM_W-1:UDATA_W]) ? '1 : vq_quot[UDATA_W-1:0];
    // stage h
    h_c_d     = sq_c;
    h_c_d.den = {1'b0, sq_root} + {{(DEN_W-COEF_W){1'b0}}, cfg.eps};
    h_c_d.neg = sq_c.m1[DATA_W-1];
    h_mabs_d  = sq_c.m1[DATA_W-1] ? (~sq_c.m1 + DATA_W'(1)) : sq_c.m1;
    // stage i
    qx       = {{(64-QNUM_W){1'b0}}, mq_quot};
    i_mhat_d = sat_s(mq_c.neg ? -qx : qx);
    // stage j
    hx    = {{(PROD_W-DATA_W){i_mhat_q[DATA_W-1]}}, i_mhat_q};
    j_p_d = $signed({{(PROD_W-COEF_W){1'b0}}, cfg.lr}) * hx;
    // stage k
    px        = sxp(j_p_q);
    px        = j_p_q[PROD_W-1] ? -px : px;
    k_pabs_d  = px[QNUM_W-1:0];
    k_c_d     = j_c_q;
    k_c_d.neg = j_p_q[PROD_W-1];
    // stage l
    qx       = {{(64-QNUM_W){1'b0}}, fq_quot};
    l_step_d = (cfg.mode == MODE_SGD) ? fq_c.sgd_step : sat_s(fq_c.neg ? -qx : qx);
    // output
    out_d.weight_out     = sat_s(sx32(l_c_q.w) - sx32(l_step_q));
    out_d.moment_one_out = (cfg.mode == MODE_SGD) ? l_c_q.m_in : l_c_q.m1;
    out_d.moment_two_out = (cfg.mode == MODE_SGD) ? l_c_q.v_in : l_c_q.v1;
  end

  adam_div_pipe #(.NUM_W(VNUM_W), .DEN_W(COEF_W), .TAG_W(TAG_W)) u_div_v (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(f_vld_q),
    .num_i({f_c_q.v1, {FRAC_W{1'b0}}}), .den_i(cfg.bc2), .tag_i(f_c_q),
    .valid_o(vq_vld), .quot_o(vq_quot), .tag_o(vq_t)
  );
  assign vq_c = vq_t;

  adam_sqrt_pipe #(.ROOT_W(ROOT_W), .TAG_W(TAG_W)) u_sqrt (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(g_vld_q),
    .x_i({1'b0, g_vhat_q, {FRAC_W{1'b0}}}), .tag_i(g_c_q),
    .valid_o(sq_vld), .root_o(sq_root), .tag_o(sq_t)
  );
  assign sq_c = sq_t;

  adam_div_pipe #(.NUM_W(QNUM_W), .DEN_W(COEF_W), .TAG_W(TAG_W)) u_div_m (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(h_vld_q),
    .num_i({h_mabs_q, {FRAC_W{1'b0}}}), .den_i(cfg.bc1), .tag_i(h_c_q),
    .valid_o(mq_vld), .quot_o(mq_quot), .tag_o(mq_t)
  );
  assign mq_c = mq_t;

  adam_div_pipe #(.NUM_W(QNUM_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div_f (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(k_vld_q),
    .num_i(k_pabs_q), .den_i(k_c_q.den), .tag_i(k_c_q),
    .valid_o(fq_vld), .quot_o(fq_quot), .tag_o(fq_t)
  );
  assign fq_c = fq_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      e_vld_q   <= 1'b0;
      f_vld_q   <= 1'b0;
      g_vld_q   <= 1'b0;
      h_vld_q   <= 1'b0;
      i_vld_q   <= 1'b0;
      j_vld_q   <= 1'b0;
      k_vld_q   <= 1'b0;
      l_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q   <= gq_vld;
      c_vld_q   <= b_vld_q;
      d_vld_q   <= c_vld_q;
      e_vld_q   <= d_vld_q;
      f_vld_q   <= e_vld_q;
      g_vld_q   <= vq_vld;
      h_vld_q   <= sq_vld;
      i_vld_q   <= mq_vld;
      j_vld_q   <= i_vld_q;
      k_vld_q   <= j_vld_q;
      l_vld_q   <= fq_vld;
      out_vld_q <= l_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_c_q    <= gq_c;
      b_g_q    <= b_g_d;
      c_c_q    <= b_c_q;
      c_pm_q   <= c_pm_d;
      c_pg_q   <= c_pg_d;
      c_plr_q  <= c_plr_d;
      c_pgg_q  <= c_pgg_d;
      d_c_q    <= d_c_d;
      d_gg_q   <= d_gg_d;
      e_c_q    <= d_c_q;
      e_pv_q   <= e_pv_d;
      e_pg_q   <= e_pg_d;
      f_c_q    <= f_c_d;
      g_c_q    <= vq_c;
      g_vhat_q <= g_vhat_d;
      h_c_q    <= h_c_d;
      h_mabs_q <= h_mabs_d;
      i_c_q    <= mq_c;
      i_mhat_q <= i_mhat_d;
      j_c_q    <= i_c_q;
      j_p_q    <= j_p_d;
      k_c_q    <= k_c_d;
      k_pabs_q <= k_pabs_d;
      l_c_q    <= fq_c;
      l_step_q <= l_step_d;
      out_q    <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  a_sgd_m: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && l_vld_q && cfg.mode == MODE_SGD |=> out_q.moment_one_out == $past(l_c_q.m_in))
    else $error("sgd first moment altered");
  a_sgd_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && l_vld_q && cfg.mode == MODE_SGD |=> out_q.moment_two_out == $past(l_c_q.v_in))
    else $error("sgd second moment altered");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && l_vld_q |=> out_vld_q) else $error("item lost at output");

endmodule
